[rtl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Shared types, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int PER_W  = 32;
  localparam int TICK_W = 64;
  localparam int RUN_W  = 32;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FAULTED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4,
    ST_CB_FAIL   = 3'd5,
    ST_NOT_FOUND = 3'd6
  } stat_t;

  typedef enum logic [1:0] {
    IDS_ZERO  = 2'd0,
    IDS_ITEM  = 2'd1,
    IDS_ENTRY = 2'd2,
    IDS_FAULT = 2'd3
  } id_sel_t;

  typedef enum logic [1:0] {
    TKS_CUR  = 2'd0,
    TKS_INC  = 2'd1,
    TKS_ZERO = 2'd2
  } tick_sel_t;

  typedef struct packed {
    logic      load;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_dec;
    logic      div_start;
    logic      ins_shift;
    logic      ins_write;
    logic      run_upd;
    logic      stat_clr;
    logic      tick_inc;
    logic      glob_clr;
    logic      fault_set;
    logic      emit;
    logic      emit_kind;
    stat_t     emit_status;
    id_sel_t   id_sel;
    tick_sel_t tick_sel;
    logic      emit_stats;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic at_zero;
    logic id_hit;
    logic id_zero;
    logic due;
    logic fail_hit;
    logic goes_first;
    logic invalid;
    logic full;
    logic faulted;
    logic rem_done;
  } sts_t;

endpackage

[rtl/ptd_rem.sv]
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial remainder of a 64-bit dividend by a 32-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptd_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  import ptd_pkg::*;

  localparam int DW = 64;
  localparam int SW = $clog2(DW);

  logic [DW-1:0] quo_r;
  logic [31:0]   rem_r;
  logic [SW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [32:0]   trial;
  logic [32:0]   diff;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == SW'(DW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[DW-2:0], 1'b0};
      // Trial subtraction; the result always fits the divisor's width.
      if (!diff[32]) begin
        rem_r <= diff[31:0];
      end else begin
        rem_r <= trial[31:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[rtl/ptd_ctrl.sv]
// ----------------------------------------------------------------------------
// Dispatcher controller
// Sequences add, tick, statistics reset and query items over the task table
// by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module ptd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ptd_pkg::act_t action,
  input  ptd_pkg::sts_t sts,
  output ptd_pkg::cmd_t cmd,
  output logic          busy
);
  import ptd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_CHK, S_DUP, S_DIV, S_SHIFT, S_TICK, S_FAIL, S_CLR, S_QUERY
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd             = '0;
    cmd.emit_status = ST_OK;
    cmd.id_sel      = IDS_ZERO;
    cmd.tick_sel    = TKS_CUR;
    state_nxt       = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (action)
            ACT_ADD:   state_nxt = S_ADD_CHK;
            ACT_TICK: begin
              if (sts.faulted) begin
                cmd.emit        = 1'b1;
                cmd.emit_kind   = KIND_STATUS;
                cmd.emit_status = ST_FAULTED;
                cmd.id_sel      = IDS_FAULT;
                cmd.emit_last   = 1'b1;
              end else begin
                state_nxt = S_TICK;
              end
            end
            ACT_RESET: state_nxt = S_CLR;
            ACT_QUERY: state_nxt = S_QUERY;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: begin
        cmd.emit_kind = KIND_STATUS;
        cmd.id_sel    = IDS_ITEM;
        cmd.emit_last = 1'b1;
        priority if (sts.invalid) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_INVALID;
          state_nxt       = S_IDLE;
        end else if (sts.faulted) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FAULTED;
          state_nxt       = S_IDLE;
        end else if (sts.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_DUP;
        end
      end
      S_DUP: begin
        priority if (sts.at_end) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (sts.id_hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_status = ST_DUP;
          cmd.id_sel      = IDS_ITEM;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.rem_done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sts.at_zero && sts.goes_first) begin
          cmd.ins_shift = 1'b1;
          cmd.idx_dec   = 1'b1;
        end else begin
          cmd.ins_write = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STATUS;
          cmd.id_sel    = IDS_ITEM;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK: begin
        priority if (sts.at_end) begin
          cmd.tick_inc  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STATUS;
          cmd.tick_sel  = TKS_INC;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.due) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_DISPATCH;
          cmd.id_sel    = IDS_ENTRY;
          if (sts.fail_hit) begin
            cmd.fault_set = 1'b1;
            state_nxt     = S_FAIL;
          end else begin
            cmd.run_upd = 1'b1;
            cmd.idx_inc = 1'b1;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FAIL: begin
        cmd.emit        = 1'b1;
        cmd.emit_kind   = KIND_STATUS;
        cmd.emit_status = ST_CB_FAIL;
        cmd.id_sel      = IDS_ENTRY;
        cmd.emit_last   = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_CLR: begin
        if (sts.at_end) begin
          cmd.glob_clr  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STATUS;
          cmd.tick_sel  = TKS_ZERO;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.stat_clr = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_QUERY: begin
        priority if (sts.at_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_status = ST_NOT_FOUND;
          cmd.id_sel      = IDS_ITEM;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else if (!sts.id_zero && sts.id_hit) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_STATUS;
          cmd.id_sel     = IDS_ITEM;
          cmd.emit_stats = 1'b1;
          cmd.emit_last  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> (state_r == S_IDLE))
    else $error("final beat did not return the controller to idle");

  a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.rem_done) |=> (state_r == S_DIV))
    else $error("insertion started before the remainder was ready");

  a_fail_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FAIL) |-> (cmd.emit && cmd.emit_status == ST_CB_FAIL))
    else $error("failing callback not reported");

endmodule

[rtl/ptd_dpath.sv]
// ----------------------------------------------------------------------------
// Dispatcher datapath
// Task table, tick counter, fault state, item registers and the registered
// result beat. Each entry keeps the tick of its next release.
// ----------------------------------------------------------------------------
module ptd_dpath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptd_pkg::cmd_t              cmd,
  output ptd_pkg::sts_t              sts,
  input  logic [ptd_pkg::ID_W-1:0]   in_task_id,
  input  logic [ptd_pkg::PRI_W-1:0]  in_priority_req,
  input  logic [ptd_pkg::PER_W-1:0]  in_period,
  input  logic [ptd_pkg::PER_W-1:0]  in_phase,
  input  logic [ptd_pkg::ID_W-1:0]   in_fail_id,
  output logic                       out_valid,
  output logic                       out_kind,
  output logic [ptd_pkg::ID_W-1:0]   out_task_id,
  output logic [ptd_pkg::TICK_W-1:0] out_tick,
  output logic [2:0]                 out_status,
  output logic [ptd_pkg::RUN_W-1:0]  out_run_total,
  output logic [ptd_pkg::TICK_W-1:0] out_last_run,
  output logic                       out_last
);
  import ptd_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = TICK_W + 1;

  logic [ID_W-1:0]   itm_id_r;
  logic [PRI_W-1:0]  itm_pri_r;
  logic [PER_W-1:0]  itm_per_r;
  logic [PER_W-1:0]  itm_ph_r;
  logic [ID_W-1:0]   itm_fail_r;

  logic [ID_W-1:0]   tbl_id_r   [MAX_ENTRIES];
  logic [PRI_W-1:0]  tbl_pri_r  [MAX_ENTRIES];
  logic [PER_W-1:0]  tbl_per_r  [MAX_ENTRIES];
  logic [PER_W-1:0]  tbl_ph_r   [MAX_ENTRIES];
  logic [RUN_W-1:0]  tbl_runs_r [MAX_ENTRIES];
  logic [TICK_W-1:0] tbl_last_r [MAX_ENTRIES];
  logic [NW-1:0]     tbl_next_r [MAX_ENTRIES];

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic [TICK_W-1:0] tick_r;
  logic              fault_r;
  logic [ID_W-1:0]   ftask_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TICK_W-1:0] out_tick_r;
  logic [2:0]        out_status_r;
  logic [RUN_W-1:0]  out_runs_r;
  logic [TICK_W-1:0] out_lrun_r;
  logic              out_last_r;

  logic [IW-1:0]     ix;
  logic [IW-1:0]     ixm1;
  logic              rem_done;
  logic [31:0]       rem;
  logic [NW-1:0]     new_next;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] phase_ext;

  assign ix        = idx_r[IW-1:0];
  assign ixm1      = ix - 1'b1;
  assign tick_inc  = tick_r + 1'b1;
  assign phase_ext = {{(TICK_W-PER_W){1'b0}}, itm_ph_r};

  ptd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tick_r - phase_ext),
    .divisor  (itm_per_r),
    .done     (rem_done),
    .rem      (rem)
  );

  // First release at or after the current tick.
  always_comb begin
    if (tick_r <= phase_ext) begin
      new_next = {1'b0, phase_ext};
    end else if (rem == '0) begin
      new_next = {1'b0, tick_r};
    end else begin
      new_next = {1'b0, tick_r} + {{(NW-PER_W){1'b0}}, itm_per_r - rem};
    end
  end

  always_comb begin
    sts.at_end     = (idx_r == cnt_r);
    sts.at_zero    = (idx_r == '0);
    sts.id_hit     = (tbl_id_r[ix] == itm_id_r);
    sts.id_zero    = (itm_id_r == '0);
    sts.due        = (tbl_next_r[ix] == {1'b0, tick_r});
    sts.fail_hit   = (itm_fail_r != '0) && (tbl_id_r[ix] == itm_fail_r);
    sts.goes_first = (itm_pri_r < tbl_pri_r[ixm1]) ||
                     ((itm_pri_r == tbl_pri_r[ixm1]) && (itm_id_r < tbl_id_r[ixm1]));
    sts.invalid    = (itm_id_r == '0) || (itm_per_r == '0) || (itm_ph_r >= itm_per_r);
    sts.full       = (cnt_r >= CW'(MAX_ENTRIES));
    sts.faulted    = fault_r;
    sts.rem_done   = rem_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm_id_r   <= in_task_id;
      itm_pri_r  <= in_priority_req;
      itm_per_r  <= in_period;
      itm_ph_r   <= in_phase;
      itm_fail_r <= in_fail_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      tbl_id_r[ix]   <= tbl_id_r[ixm1];
      tbl_pri_r[ix]  <= tbl_pri_r[ixm1];
      tbl_per_r[ix]  <= tbl_per_r[ixm1];
      tbl_ph_r[ix]   <= tbl_ph_r[ixm1];
      tbl_runs_r[ix] <= tbl_runs_r[ixm1];
      tbl_last_r[ix] <= tbl_last_r[ixm1];
      tbl_next_r[ix] <= tbl_next_r[ixm1];
    end else if (cmd.ins_write) begin
      tbl_id_r[ix]   <= itm_id_r;
      tbl_pri_r[ix]  <= itm_pri_r;
      tbl_per_r[ix]  <= itm_per_r;
      tbl_ph_r[ix]   <= itm_ph_r;
      tbl_runs_r[ix] <= '0;
      tbl_last_r[ix] <= '1;
      tbl_next_r[ix] <= new_next;
    end else if (cmd.run_upd) begin
      if (tbl_runs_r[ix] != '1) begin
        tbl_runs_r[ix] <= tbl_runs_r[ix] + 1'b1;
      end
      tbl_last_r[ix] <= tick_r;
      tbl_next_r[ix] <= tbl_next_r[ix] + {{(NW-PER_W){1'b0}}, tbl_per_r[ix]};
    end else if (cmd.stat_clr) begin
      tbl_runs_r[ix] <= '0;
      tbl_last_r[ix] <= '1;
      tbl_next_r[ix] <= {{(NW-PER_W){1'b0}}, tbl_ph_r[ix]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      tick_r      <= '0;
      fault_r     <= 1'b0;
      ftask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cmd.ins_write) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.glob_clr) begin
        tick_r  <= '0;
        fault_r <= 1'b0;
        ftask_r <= '0;
      end else begin
        if (cmd.tick_inc) begin
          tick_r <= tick_inc;
        end
        if (cmd.fault_set) begin
          fault_r <= 1'b1;
          ftask_r <= itm_fail_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.emit_kind;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
      unique case (cmd.id_sel)
        IDS_ZERO:  out_id_r <= '0;
        IDS_ITEM:  out_id_r <= itm_id_r;
        IDS_ENTRY: out_id_r <= tbl_id_r[ix];
        IDS_FAULT: out_id_r <= ftask_r;
        default:   out_id_r <= '0;
      endcase
      unique case (cmd.tick_sel)
        TKS_CUR:  out_tick_r <= tick_r;
        TKS_INC:  out_tick_r <= tick_inc;
        TKS_ZERO: out_tick_r <= '0;
        default:  out_tick_r <= tick_r;
      endcase
      if (cmd.emit_stats) begin
        out_runs_r <= tbl_runs_r[ix];
        out_lrun_r <= tbl_last_r[ix];
      end else begin
        out_runs_r <= '0;
        out_lrun_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_task_id   = out_id_r;
  assign out_tick      = out_tick_r;
  assign out_status    = out_status_r;
  assign out_run_total = out_runs_r;
  assign out_last_run  = out_lrun_r;
  assign out_last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("task count beyond table depth");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick_inc && !cmd.glob_clr) |=> (tick_r == $past(tick_inc)))
    else $error("tick did not advance by one");

  a_dispatch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_DISPATCH) |-> !out_last_r)
    else $error("dispatch beat marked as final");

  a_fault_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fault_set && !cmd.glob_clr) |=> (fault_r && ftask_r == $past(itm_fail_r)))
    else $error("fault not recorded after a failing callback");

endmodule

[rtl/periodic_task_dispatcher.sv]
// ----------------------------------------------------------------------------
// Periodic task dispatcher
// Fixed-priority table of periodic tasks with add, tick, statistics reset
// and query commands; one item is handled at a time.
// ----------------------------------------------------------------------------
// Tick walks the task table one table entry per cycle, as do query, reset
// and the duplicate search of add, which then runs the remainder unit and
// one insertion shift per cycle.
// One item at a time: busy stays high until the final beat has been issued.
// Result beats are single-cycle strobes; the receiver cannot stall them.
// Synchronous active-low reset empties the table and clears tick and fault.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [ptd_pkg::ID_W-1:0]   in_task_id,
  input  logic [ptd_pkg::PRI_W-1:0]  in_priority_req,
  input  logic [ptd_pkg::PER_W-1:0]  in_period,
  input  logic [ptd_pkg::PER_W-1:0]  in_phase,
  input  logic [ptd_pkg::ID_W-1:0]   in_fail_id,
  output logic                       out_valid,
  output logic                       out_kind,
  output logic [ptd_pkg::ID_W-1:0]   out_task_id,
  output logic [ptd_pkg::TICK_W-1:0] out_tick,
  output logic [2:0]                 out_status,
  output logic [ptd_pkg::RUN_W-1:0]  out_run_total,
  output logic [ptd_pkg::TICK_W-1:0] out_last_run,
  output logic                       out_last
);
  import ptd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  act_t action;

  assign action = act_t'(in_action);

  ptd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  ptd_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .in_period       (in_period),
    .in_phase        (in_phase),
    .in_fail_id      (in_fail_id),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_task_id     (out_task_id),
    .out_tick        (out_tick),
    .out_status      (out_status),
    .out_run_total   (out_run_total),
    .out_last_run    (out_last_run),
    .out_last        (out_last)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Periodic task dispatcher testbench
// Drives add, tick, statistics reset and query items at the command port and
// checks every result beat against a behavioural model of the task table.
// The random run has four phases, two of which let the sender idle.
// ----------------------------------------------------------------------------
module tb_top;
  import ptd_pkg::*;

  class dispatch_scoreboard;
    typedef struct {
      bit        kind;
      bit [15:0] id;
      bit [63:0] tick;
      bit [2:0]  st;
      bit [31:0] runs;
      bit [63:0] lr;
      bit        last;
    } beat_t;

    bit [15:0]   tbl_id[16];
    bit [7:0]    tbl_pri[16];
    bit [31:0]   tbl_per[16];
    bit [31:0]   tbl_ph[16];
    bit [31:0]   tbl_runs[16];
    bit [63:0]   tbl_last[16];
    int unsigned used;
    bit [63:0]   tick_now;
    bit          faulted;
    bit [15:0]   fault_id;
    beat_t       beats_q[$];
    int          errors;

    function void push(bit kind, bit [15:0] id, bit [63:0] tick, bit [2:0] st,
                       bit [31:0] runs, bit [63:0] lr, bit last);
      beat_t b;
      b = '{kind, id, tick, st, runs, lr, last};
      beats_q.push_back(b);
    endfunction

    function bit [2:0] add_task(bit [15:0] id, bit [7:0] pri, bit [31:0] per,
                                bit [31:0] ph);
      int unsigned pos;
      if (id == 0 || per == 0 || ph >= per) return ST_INVALID;
      if (faulted) return ST_FAULTED;
      if (used >= 16) return ST_FULL;
      for (int i = 0; i < used; i++) if (tbl_id[i] == id) return ST_DUP;
      pos = used;
      while (pos > 0 && (pri < tbl_pri[pos-1] ||
                         (pri == tbl_pri[pos-1] && id < tbl_id[pos-1]))) begin
        tbl_id[pos]   = tbl_id[pos-1];
        tbl_pri[pos]  = tbl_pri[pos-1];
        tbl_per[pos]  = tbl_per[pos-1];
        tbl_ph[pos]   = tbl_ph[pos-1];
        tbl_runs[pos] = tbl_runs[pos-1];
        tbl_last[pos] = tbl_last[pos-1];
        pos--;
      end
      tbl_id[pos]   = id;
      tbl_pri[pos]  = pri;
      tbl_per[pos]  = per;
      tbl_ph[pos]   = ph;
      tbl_runs[pos] = '0;
      tbl_last[pos] = '1;
      used++;
      return ST_OK;
    endfunction

    function void note_item(act_t a, bit [15:0] id, bit [7:0] pri, bit [31:0] per,
                            bit [31:0] ph, bit [15:0] fail);
      bit [63:0] t;
      bit [2:0]  st;
      case (a)
        ACT_ADD: begin
          st = add_task(id, pri, per, ph);
          push(KIND_STATUS, id, tick_now, st, '0, '0, 1'b1);
        end
        ACT_TICK: begin
          t = tick_now;
          if (faulted) begin
            push(KIND_STATUS, fault_id, t, ST_FAULTED, '0, '0, 1'b1);
            return;
          end
          for (int i = 0; i < used; i++) begin
            if (t >= tbl_ph[i] && ((t - tbl_ph[i]) % tbl_per[i]) == 0) begin
              push(KIND_DISPATCH, tbl_id[i], t, ST_OK, '0, '0, 1'b0);
              if (fail != 0 && tbl_id[i] == fail) begin
                faulted  = 1'b1;
                fault_id = fail;
                push(KIND_STATUS, fail, t, ST_CB_FAIL, '0, '0, 1'b1);
                return;
              end
              if (tbl_runs[i] != '1) tbl_runs[i]++;
              tbl_last[i] = t;
            end
          end
          tick_now = t + 64'd1;
          push(KIND_STATUS, '0, tick_now, ST_OK, '0, '0, 1'b1);
        end
        ACT_RESET: begin
          tick_now = '0;
          faulted  = 1'b0;
          fault_id = '0;
          for (int i = 0; i < used; i++) begin
            tbl_runs[i] = '0;
            tbl_last[i] = '1;
          end
          push(KIND_STATUS, '0, '0, ST_OK, '0, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < used; i++) begin
            if (id != 0 && tbl_id[i] == id) begin
              push(KIND_STATUS, id, tick_now, ST_OK, tbl_runs[i], tbl_last[i], 1'b1);
              return;
            end
          end
          push(KIND_STATUS, id, tick_now, ST_NOT_FOUND, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void cmp(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(logic kind, logic [15:0] id, logic [63:0] tick,
                             logic [2:0] st, logic [31:0] runs, logic [63:0] lr,
                             logic last);
      beat_t b;
      if (beats_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual id %h status %0d",
                 $time, id, st);
        errors++;
        return;
      end
      b = beats_q.pop_front();
      cmp("kind", 64'(b.kind), 64'(kind));
      cmp("task_id", 64'(b.id), 64'(id));
      cmp("tick", b.tick, tick);
      cmp("status", 64'(b.st), 64'(st));
      cmp("run_total", 64'(b.runs), 64'(runs));
      cmp("last_run", b.lr, lr);
      cmp("last", 64'(b.last), 64'(last));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [15:0] in_task_id = '0;
  logic [7:0]  in_priority_req = '0;
  logic [31:0] in_period = '0;
  logic [31:0] in_phase = '0;
  logic [15:0] in_fail_id = '0;
  logic        out_valid, out_kind, out_last;
  logic [15:0] out_task_id;
  logic [63:0] out_tick, out_last_run;
  logic [2:0]  out_status;
  logic [31:0] out_run_total;

  dispatch_scoreboard sb = new();
  int gap_pct;

  periodic_task_dispatcher i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_task_id(in_task_id),
    .in_priority_req(in_priority_req), .in_period(in_period),
    .in_phase(in_phase), .in_fail_id(in_fail_id),
    .out_valid(out_valid), .out_kind(out_kind), .out_task_id(out_task_id),
    .out_tick(out_tick), .out_status(out_status),
    .out_run_total(out_run_total), .out_last_run(out_last_run),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat(out_kind, out_task_id, out_tick, out_status, out_run_total,
                    out_last_run, out_last);
  end

  // Start stays high between back-to-back items; it is only lowered for a gap.
  // The item is presented once busy is low, so it is taken at the next edge.
  task automatic send_item(act_t a, bit [15:0] id, bit [7:0] pri, bit [31:0] per,
                           bit [31:0] ph, bit [15:0] fail);
    int idle;
    if ($urandom_range(99) < gap_pct) begin
      idle = $urandom_range(1, 4);
      @(negedge clk);
      start <= 0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    while (busy) @(negedge clk);
    start           <= 1;
    in_action       <= a;
    in_task_id      <= id;
    in_priority_req <= pri;
    in_period       <= per;
    in_phase        <= ph;
    in_fail_id      <= fail;
    sb.note_item(a, id, pri, per, ph, fail);
    @(posedge clk);
  endtask

  function automatic bit [15:0] pick_id();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 20));
  endfunction

  task automatic random_item();
    int        sel;
    bit [15:0] id;
    bit [31:0] per, ph;
    bit [15:0] fail;
    sel  = $urandom_range(99);
    id   = pick_id();
    per  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 6);
    ph   = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, per - 1);
    fail = 0;
    if ($urandom_range(11) == 0)
      fail = (sb.used > 0) ? sb.tbl_id[$urandom_range(sb.used - 1)] : 16'($urandom);
    else if ($urandom_range(9) == 0)
      fail = 16'($urandom);
    if (sel < 25)
      send_item(ACT_ADD, id, 8'($urandom), per, ph, fail);
    else if (sel < 70)
      send_item(ACT_TICK, id, 8'($urandom), $urandom, $urandom, fail);
    else if (sel < 80)
      send_item(ACT_RESET, id, 8'($urandom), $urandom, $urandom, fail);
    else begin
      if (sb.used > 0 && $urandom_range(3) != 0) id = sb.tbl_id[$urandom_range(sb.used - 1)];
      send_item(ACT_QUERY, id, 8'($urandom), $urandom, $urandom, fail);
    end
  endtask

  initial begin
    int pct[4];
    pct = '{0, 47, 0, 35};
    gap_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;

    send_item(ACT_ADD, 16'h0000, 8'h10, 32'd4, 32'd0, 16'h0);
    send_item(ACT_ADD, 16'h0002, 8'h10, 32'd0, 32'd0, 16'h0);
    send_item(ACT_ADD, 16'h0003, 8'h10, 32'd5, 32'd5, 16'h0);
    send_item(ACT_ADD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 16'hFFFF);
    send_item(ACT_ADD, 16'h0001, 8'h00, 32'd1, 32'd0, 16'h0);
    send_item(ACT_ADD, 16'h0004, 8'h00, 32'd2, 32'd1, 16'h0);
    send_item(ACT_ADD, 16'h0001, 8'h05, 32'd3, 32'd0, 16'h0);
    send_item(ACT_QUERY, 16'h0001, 8'h00, 32'd0, 32'd0, 16'h0);
    send_item(ACT_QUERY, 16'h0000, 8'h00, 32'd0, 32'd0, 16'h0);
    send_item(ACT_QUERY, 16'h0055, 8'h00, 32'd0, 32'd0, 16'h0);
    repeat (3) send_item(ACT_TICK, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);
    send_item(ACT_TICK, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0004);
    send_item(ACT_TICK, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);
    send_item(ACT_ADD, 16'h0009, 8'h01, 32'd2, 32'd0, 16'h0);
    send_item(ACT_QUERY, 16'h0004, 8'h00, 32'd0, 32'd0, 16'h0);
    send_item(ACT_RESET, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);
    send_item(ACT_QUERY, 16'hFFFF, 8'h00, 32'd0, 32'd0, 16'h0);
    send_item(ACT_TICK, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);

    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      gap_pct = pct[ph_i];
      repeat (15) random_item();
    end
    // Clear any fault, then fill the table so that the full status is seen.
    send_item(ACT_RESET, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);
    for (int k = 0; k < 17; k++)
      send_item(ACT_ADD, 16'(100 + k), 8'($urandom), 32'd3, 32'd1, 16'h0);
    repeat (6) send_item(ACT_TICK, 16'h0, 8'h0, 32'd0, 32'd0, 16'h0);

    @(negedge clk);
    start <= 0;
    while (sb.beats_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.beats_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
